### rtl/core/ihex_pkg.sv
// Shared constants, command word type and a hex digit helper for the Intel HEX encoder.
package ihex_pkg;

  // Data bytes gathered into one record
  localparam int RECORD_BYTES = 16;
  // Fill count width (holds RECORD_BYTES itself) and buffer index width
  localparam int CNT_W = $clog2(RECORD_BYTES + 1);
  localparam int IDX_W = (RECORD_BYTES > 1) ? $clog2(RECORD_BYTES) : 1;
  // Character sequencer counter: covers 2*RECORD_BYTES digits and 16-char records
  localparam int SEQ_W = (CNT_W + 1 > 4) ? CNT_W + 1 : 4;

  // Command queue depth between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  // Request codes
  localparam logic REQ_DATA = 1'b0;
  localparam logic REQ_END  = 1'b1;

  // Sum of count, address and type bytes of an extended linear address record
  localparam logic [7:0] EXT_HDR_SUM = 8'h06;

  // ASCII characters
  localparam logic [6:0] CH_COLON = 7'h3A;
  localparam logic [6:0] CH_ZERO  = 7'h30;
  localparam logic [6:0] CH_ONE   = 7'h31;
  localparam logic [6:0] CH_TWO   = 7'h32;
  localparam logic [6:0] CH_FOUR  = 7'h34;
  localparam logic [6:0] CH_F     = 7'h46;
  localparam logic [6:0] CH_NL    = 7'h0A;

  // Work handed from front to back for one accepted item
  typedef struct packed {
    logic             is_end;   // end marker
    logic [7:0]       data;     // data byte to store
    logic [IDX_W-1:0] idx;      // buffer slot of the data byte
    logic             ext;      // extended linear address record due
    logic [15:0]      hi;       // upper address bits for the type-04 record
    logic [7:0]       ext_ck;   // type-04 checksum
    logic             flush;    // emit a data record
    logic [CNT_W-1:0] n;        // byte count of that record
    logic [15:0]      lo;       // low address bits of that record
    logic [7:0]       rec_ck;   // data record checksum
  } cmd_t;

  // Uppercase hex digit
  function automatic logic [6:0] hex_char(input logic [3:0] d);
    logic [6:0] c;
    if (d < 4'd10) begin
      c = CH_ZERO + 7'(d);
    end else begin
      c = 7'h41 + 7'(d - 4'd10);
    end
    return c;
  endfunction

endpackage

### rtl/core/ihex_front.sv
// Front end: accepts items, tracks address, fill and sum, and issues command words.
module ihex_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic              req_type,
  input  logic [7:0]        data_byte,
  output logic              full,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [31:0]       cfg_data,
  input  logic              q_full,
  output logic              q_wr,
  output ihex_pkg::cmd_t    q_wdata
);
  import ihex_pkg::*;

  logic [31:0]      base_addr;
  logic [31:0]      addr;
  logic [CNT_W-1:0] fill;
  logic [7:0]       sum;

  logic [CNT_W-1:0] fill_next;
  logic [7:0]       sum_next;
  logic             rec_full;
  logic [CNT_W-1:0] rec_n;
  logic [7:0]       rec_sum;

  assign full      = q_full;
  assign cfg_ready = 1'b1;
  assign q_wr      = push && !q_full;

  // Classify the item and build its command word
  always_comb begin
    fill_next = fill + CNT_W'(1);
    sum_next  = sum + data_byte;
    rec_full  = (fill_next >= CNT_W'(RECORD_BYTES));
    rec_n     = (req_type == REQ_END) ? fill : fill_next;
    rec_sum   = (req_type == REQ_END) ? sum : sum_next;

    q_wdata.is_end = (req_type == REQ_END);
    q_wdata.data   = data_byte;
    q_wdata.idx    = fill[IDX_W-1:0];
    q_wdata.ext    = (req_type == REQ_DATA) && (fill == '0) && (addr[15:0] == 16'h0000);
    q_wdata.hi     = addr[31:16];
    q_wdata.ext_ck = 8'h00 - (EXT_HDR_SUM + addr[31:24] + addr[23:16]);
    q_wdata.flush  = (req_type == REQ_END) ? (fill != '0) : rec_full;
    q_wdata.n      = rec_n;
    q_wdata.lo     = addr[15:0];
    q_wdata.rec_ck = 8'h00 - (8'(rec_n) + addr[7:0] + addr[15:8] + rec_sum);
  end

  // Hold stream state; restart on config write or end marker
  always_ff @(posedge clk) begin
    if (rst) begin
      base_addr <= '0;
      addr      <= '0;
      fill      <= '0;
      sum       <= '0;
    end else if (cfg_valid && cfg_ready) begin
      base_addr <= cfg_data;
      addr      <= cfg_data;
      fill      <= '0;
      sum       <= '0;
    end else if (q_wr) begin
      if (req_type == REQ_END) begin
        addr <= base_addr;
        fill <= '0;
        sum  <= '0;
      end else if (rec_full) begin
        addr <= addr + 32'(fill_next);
        fill <= '0;
        sum  <= '0;
      end else begin
        fill <= fill_next;
        sum  <= sum_next;
      end
    end
  end

endmodule

### rtl/core/ihex_cmd_fifo.sv
// Short command queue between front and back.
module ihex_cmd_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr,
  input  ihex_pkg::cmd_t  wdata,
  output logic            full,
  input  logic            rd,
  output ihex_pkg::cmd_t  rdata,
  output logic            empty
);
  import ihex_pkg::*;

  cmd_t              mem [QDEPTH];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  logic [QPTR_W:0]   count;

  assign full  = (count == (QPTR_W + 1)'(QDEPTH));
  assign empty = (count == '0);
  assign rdata = mem[rptr];

  // Store words
  always_ff @(posedge clk) begin
    if (wr && !full) begin
      mem[wptr] <= wdata;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr && !full) begin
        wptr <= wptr + QPTR_W'(1);
      end
      if (rd && !empty) begin
        rptr <= rptr + QPTR_W'(1);
      end
      if ((wr && !full) && !(rd && !empty)) begin
        count <= count + (QPTR_W + 1)'(1);
      end else if (!(wr && !full) && (rd && !empty)) begin
        count <= count - (QPTR_W + 1)'(1);
      end
    end
  end

endmodule

### rtl/core/ihex_back.sv
// Back end: stores record bytes and sequences the record text one character at a time.
module ihex_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_empty,
  input  ihex_pkg::cmd_t    q_rdata,
  output logic              q_rd,
  output logic              empty,
  input  logic              pop,
  output logic [6:0]        text_char,
  output logic              last_of_run
);
  import ihex_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_EXT  = 3'd1;
  localparam logic [2:0] ST_HEAD = 3'd2;
  localparam logic [2:0] ST_DATA = 3'd3;
  localparam logic [2:0] ST_TAIL = 3'd4;
  localparam logic [2:0] ST_END  = 3'd5;

  logic [2:0]       state;
  logic [SEQ_W-1:0] cnt;
  cmd_t             cur;
  logic [7:0]       rec_buf [RECORD_BYTES];

  logic             out_valid;
  logic [6:0]       ch;
  logic             ch_last;
  logic             phase_done;
  logic             adv;
  logic [7:0]       buf_byte;

  assign empty = !out_valid;
  assign q_rd  = (state == ST_IDLE) && !q_empty;
  assign adv   = (state != ST_IDLE) && (!out_valid || pop);
  assign buf_byte = rec_buf[cnt[IDX_W:1]];

  // Pick the character for the current sequencer position
  always_comb begin
    ch         = CH_NL;
    ch_last    = 1'b0;
    phase_done = 1'b0;
    unique case (state)
      ST_EXT: begin
        unique case (cnt[3:0])
          4'd0:    ch = CH_COLON;
          4'd2:    ch = CH_TWO;
          4'd8:    ch = CH_FOUR;
          4'd9:    ch = hex_char(cur.hi[15:12]);
          4'd10:   ch = hex_char(cur.hi[11:8]);
          4'd11:   ch = hex_char(cur.hi[7:4]);
          4'd12:   ch = hex_char(cur.hi[3:0]);
          4'd13:   ch = hex_char(cur.ext_ck[7:4]);
          4'd14:   ch = hex_char(cur.ext_ck[3:0]);
          4'd15:   ch = CH_NL;
          default: ch = CH_ZERO;
        endcase
        phase_done = (cnt == SEQ_W'(15));
        ch_last    = phase_done && !cur.flush;
      end
      ST_HEAD: begin
        unique case (cnt[3:0])
          4'd0:    ch = CH_COLON;
          4'd1:    ch = hex_char(4'(8'(cur.n) >> 4));
          4'd2:    ch = hex_char(cur.n[3:0]);
          4'd3:    ch = hex_char(cur.lo[15:12]);
          4'd4:    ch = hex_char(cur.lo[11:8]);
          4'd5:    ch = hex_char(cur.lo[7:4]);
          4'd6:    ch = hex_char(cur.lo[3:0]);
          default: ch = CH_ZERO;
        endcase
        phase_done = (cnt == SEQ_W'(8));
      end
      ST_DATA: begin
        ch = cnt[0] ? hex_char(buf_byte[3:0]) : hex_char(buf_byte[7:4]);
        phase_done = cnt[0] && (cnt[CNT_W:1] == (cur.n - CNT_W'(1)));
      end
      ST_TAIL: begin
        unique case (cnt[1:0])
          2'd0:    ch = hex_char(cur.rec_ck[7:4]);
          2'd1:    ch = hex_char(cur.rec_ck[3:0]);
          default: ch = CH_NL;
        endcase
        phase_done = (cnt == SEQ_W'(2));
        ch_last    = phase_done && !cur.is_end;
      end
      ST_END: begin
        unique case (cnt[3:0])
          4'd0:    ch = CH_COLON;
          4'd8:    ch = CH_ONE;
          4'd9:    ch = CH_F;
          4'd10:   ch = CH_F;
          4'd11:   ch = CH_NL;
          default: ch = CH_ZERO;
        endcase
        phase_done = (cnt == SEQ_W'(11));
        ch_last    = phase_done;
      end
      default: begin
        ch = CH_NL;
      end
    endcase
  end

  // Store data bytes as their commands are taken
  always_ff @(posedge clk) begin
    if (q_rd && !q_rdata.is_end) begin
      rec_buf[q_rdata.idx] <= q_rdata.data;
    end
  end

  // Latch the command being worked on
  always_ff @(posedge clk) begin
    if (q_rd) begin
      cur <= q_rdata;
    end
  end

  // Step the sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else if (q_rd) begin
      cnt <= '0;
      priority if (q_rdata.ext) begin
        state <= ST_EXT;
      end else if (q_rdata.flush) begin
        state <= ST_HEAD;
      end else if (q_rdata.is_end) begin
        state <= ST_END;
      end else begin
        state <= ST_IDLE;
      end
    end else if (adv) begin
      if (!phase_done) begin
        cnt <= cnt + SEQ_W'(1);
      end else begin
        cnt <= '0;
        unique case (state)
          ST_EXT:  state <= cur.flush ? ST_HEAD : ST_IDLE;
          ST_HEAD: state <= ST_DATA;
          ST_DATA: state <= ST_TAIL;
          ST_TAIL: state <= cur.is_end ? ST_END : ST_IDLE;
          default: state <= ST_IDLE;
        endcase
      end
    end
  end

  // Output register: load a new character or drop the taken one
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      text_char   <= ch;
      last_of_run <= ch_last;
    end
  end

endmodule

### rtl/core/binary_to_intel_hex_records.sv
// An item's command word passes the command queue and the back end's command register; its text
// leaves through the output register. Throughput: one character per cycle while pop is high;
// the back end takes a new command only when idle; a full 16-byte record line is 44 characters.
// The character sequencer in the back end sets this rate; a 4-word command queue decouples it.
// Reset (rst, synchronous, active high) clears the load address to 0, empties the queue and
// output register, and restarts the stream at address 0.
module binary_to_intel_hex_records (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic        req_type,
  input  logic [7:0]  data_byte,
  output logic        empty,
  input  logic        pop,
  output logic [6:0]  text_char,
  output logic        last_of_run,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);
  import ihex_pkg::*;

  logic q_full;
  logic q_empty;
  logic q_wr;
  logic q_rd;
  cmd_t q_wdata;
  cmd_t q_rdata;

  // Classify items and issue command words
  ihex_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .req_type  (req_type),
    .data_byte (data_byte),
    .full      (full),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .q_wr      (q_wr),
    .q_wdata   (q_wdata)
  );

  // Buffer commands between the two sides
  ihex_cmd_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .wr    (q_wr),
    .wdata (q_wdata),
    .full  (q_full),
    .rd    (q_rd),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  // Emit record text
  ihex_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_empty     (q_empty),
    .q_rdata     (q_rdata),
    .q_rd        (q_rd),
    .empty       (empty),
    .pop         (pop),
    .text_char   (text_char),
    .last_of_run (last_of_run)
  );

endmodule

### rtl/core/ihex_chk.sv
// Port-level checks of the Intel HEX encoder, bound to the top level.
module ihex_chk (
  input logic       clk,
  input logic       rst,
  input logic       full,
  input logic       empty,
  input logic       pop,
  input logic [6:0] text_char,
  input logic       last_of_run
);
  import ihex_pkg::*;

  // Nothing to deliver and room to accept right after reset
  a_reset_idle: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("not idle after reset");

  // A waiting word holds until taken
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(text_char) && $stable(last_of_run)))
    else $error("result word changed while stalled");

  // The final character of an item always closes a line
  a_last_nl: assert property (@(posedge clk) disable iff (rst)
    (!empty && last_of_run) |-> (text_char == CH_NL))
    else $error("last_of_run on a character other than newline");

  // A new line always opens with a colon
  a_colon: assert property (@(posedge clk) disable iff (rst)
    (!empty && pop && text_char == CH_NL) |=> (empty || text_char == CH_COLON))
    else $error("line does not start with colon");

endmodule

bind binary_to_intel_hex_records ihex_chk u_chk (
  .clk         (clk),
  .rst         (rst),
  .full        (full),
  .empty       (empty),
  .pop         (pop),
  .text_char   (text_char),
  .last_of_run (last_of_run)
);

### verif/binary_to_intel_hex_records_tb.sv
// Self-checking testbench for the Intel HEX record encoder: directed table, then random streams.
module binary_to_intel_hex_records_tb;

  localparam int          REC_LEN       = ihex_pkg::RECORD_BYTES;
  localparam logic [7:0]  EXT_SUM_BASE  = 8'h06;
  localparam logic [6:0]  NEWLINE       = 7'h0A;
  localparam int          MAX_WAIT      = 12;
  localparam int          SETTLE_CYCLES = 16;
  localparam int          RANDOM_ITEMS  = 500;
  localparam int          MAX_REPORTS   = 40;
  localparam int unsigned LIMIT_CYCLES  = 2_000_000;
  localparam int          DIR_ROWS      = 28;

  typedef struct packed {
    logic [6:0] ch;
    logic       last;
  } text_word_t;

  typedef enum logic [1:0] {ROW_DATA, ROW_END, ROW_CFG} row_kind_e;
  typedef enum logic [1:0] {EXP_PREDICT, EXP_END_ONLY, EXP_EXT_ZERO} typed_text_e;

  typedef struct packed {
    row_kind_e   kind;
    logic [31:0] val;
    typed_text_e want;
  } dir_row_t;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        push      = 1'b0;
  logic        full;
  logic        req_type  = 1'b0;
  logic [7:0]  data_byte = 8'h00;
  logic        empty;
  logic        pop       = 1'b0;
  logic [6:0]  text_char;
  logic        last_of_run;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_data  = 32'h0;

  // Encoder state mirror
  logic [31:0] base_addr = 32'h0;
  logic [31:0] rec_addr  = 32'h0;
  logic [7:0]  rec_bytes [REC_LEN];
  int unsigned rec_fill  = 0;
  logic [7:0]  rec_sum   = 8'h00;

  text_word_t  item_text [$];
  text_word_t  text_due [$];
  int          errors = 0;
  logic        calm = 1'b0;
  int unsigned cycle_count = 0;

  // Directed rows: stream after reset, one full record, partial flush, wrap, aligned top
  dir_row_t dir_rows [DIR_ROWS] = '{
    '{ROW_END,  32'h00, EXP_END_ONLY},
    '{ROW_DATA, 32'h00, EXP_EXT_ZERO},
    '{ROW_DATA, 32'hFF, EXP_PREDICT},
    '{ROW_DATA, 32'h55, EXP_PREDICT},
    '{ROW_DATA, 32'hAA, EXP_PREDICT},
    '{ROW_DATA, 32'h01, EXP_PREDICT},
    '{ROW_DATA, 32'h80, EXP_PREDICT},
    '{ROW_DATA, 32'h7F, EXP_PREDICT},
    '{ROW_DATA, 32'hFE, EXP_PREDICT},
    '{ROW_DATA, 32'h10, EXP_PREDICT},
    '{ROW_DATA, 32'h20, EXP_PREDICT},
    '{ROW_DATA, 32'h40, EXP_PREDICT},
    '{ROW_DATA, 32'h08, EXP_PREDICT},
    '{ROW_DATA, 32'h04, EXP_PREDICT},
    '{ROW_DATA, 32'h02, EXP_PREDICT},
    '{ROW_DATA, 32'h33, EXP_PREDICT},
    '{ROW_DATA, 32'hCC, EXP_PREDICT},
    '{ROW_DATA, 32'h5A, EXP_PREDICT},
    '{ROW_END,  32'h00, EXP_PREDICT},
    '{ROW_END,  32'hFF, EXP_END_ONLY},
    '{ROW_CFG,  32'hFFFF_FFFF, EXP_PREDICT},
    '{ROW_DATA, 32'hA5, EXP_PREDICT},
    '{ROW_DATA, 32'h5A, EXP_PREDICT},
    '{ROW_END,  32'h00, EXP_PREDICT},
    '{ROW_CFG,  32'hFFFF_0000, EXP_PREDICT},
    '{ROW_DATA, 32'hFF, EXP_PREDICT},
    '{ROW_END,  32'h00, EXP_PREDICT},
    '{ROW_CFG,  32'h0000_0000, EXP_PREDICT}
  };

  binary_to_intel_hex_records DUT (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .req_type   (req_type),
    .data_byte  (data_byte),
    .empty      (empty),
    .pop        (pop),
    .text_char  (text_char),
    .last_of_run(last_of_run),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  // Clock, period 20
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  function automatic logic [6:0] ascii_nibble(input logic [3:0] d);
    if (d < 4'd10) begin
      return 7'h30 + 7'(d);
    end
    return 7'h41 + 7'(d - 4'd10);
  endfunction

  function automatic void put_char(input logic [6:0] c);
    item_text.push_back({c, 1'b0});
  endfunction

  function automatic void put_byte_hex(input logic [7:0] b);
    put_char(ascii_nibble(b[7:4]));
    put_char(ascii_nibble(b[3:0]));
  endfunction

  function automatic void put_string(input string s);
    for (int i = 0; i < s.len(); i++) begin
      put_char(7'(s[i]));
    end
  endfunction

  function automatic string typed_text(input typed_text_e t);
    case (t)
      EXP_END_ONLY: return ":00000001FF\n";
      default:      return ":020000040000FA\n";
    endcase
  endfunction

  function automatic void restart_stream();
    rec_addr = base_addr;
    rec_fill = 0;
    rec_sum  = 8'h00;
  endfunction

  // Emit the open record as a type 00 line and advance the address past it
  function automatic void flush_open_record();
    logic [7:0]  n;
    logic [7:0]  sum;
    logic [15:0] lo;
    n   = 8'(rec_fill);
    lo  = rec_addr[15:0];
    sum = n + lo[7:0] + lo[15:8] + rec_sum;
    put_string(":");
    put_byte_hex(n);
    put_byte_hex(lo[15:8]);
    put_byte_hex(lo[7:0]);
    put_string("00");
    for (int i = 0; i < int'(rec_fill); i++) begin
      put_byte_hex(rec_bytes[i]);
    end
    put_byte_hex(8'h00 - sum);
    put_char(NEWLINE);
    rec_addr = rec_addr + 32'(rec_fill);
    rec_fill = 0;
    rec_sum  = 8'h00;
  endfunction

  // Compute the text one accepted item produces into item_text
  function automatic void encode_item(input logic rt, input logic [7:0] b);
    logic [15:0] hi;
    item_text.delete();
    if (rt == ihex_pkg::REQ_DATA) begin
      // Open an extended linear address record at a 64 KiB boundary
      if (rec_fill == 0 && rec_addr[15:0] == 16'h0000) begin
        hi = rec_addr[31:16];
        put_string(":02000004");
        put_byte_hex(hi[15:8]);
        put_byte_hex(hi[7:0]);
        put_byte_hex(8'h00 - (EXT_SUM_BASE + hi[15:8] + hi[7:0]));
        put_char(NEWLINE);
      end
      rec_bytes[rec_fill] = b;
      rec_fill++;
      rec_sum += b;
      if (rec_fill >= REC_LEN) begin
        flush_open_record();
      end
    end else begin
      if (rec_fill > 0) begin
        flush_open_record();
      end
      put_string(":00000001FF");
      put_char(NEWLINE);
      restart_stream();
    end
  endfunction

  function automatic logic [31:0] pick_load_address();
    logic [15:0] hi;
    hi = 16'($urandom);
    case ($urandom_range(0, 5))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return {hi, 16'h0000};
      3:       return {hi, 16'hFFF0 - 16'(16 * $urandom_range(0, 3))};
      4:       return 32'hFFFF_FFC0 + 32'($urandom_range(0, 63));
      default: return $urandom;
    endcase
  endfunction

  // Send one word, then queue the text it should cause
  task automatic send_item(input logic rt, input logic [7:0] b, input typed_text_e want);
    int gap;
    gap = calm ? 0 : int'($urandom_range(0, MAX_WAIT));
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push      <= 1'b1;
    req_type  <= rt;
    data_byte <= b;
    @(posedge clk);
    while (full !== 1'b0) @(posedge clk);
    encode_item(rt, b);
    if (want != EXP_PREDICT) begin
      item_text.delete();
      put_string(typed_text(want));
    end
    if (item_text.size() > 0) begin
      item_text[item_text.size() - 1].last = 1'b1;
    end
    foreach (item_text[i]) begin
      text_due.push_back(item_text[i]);
    end
  endtask

  // Hold the sender until all text has arrived and the back end has settled
  task automatic hold_until_drained();
    push <= 1'b0;
    @(posedge clk);
    while (text_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_load_address(input logic [31:0] a);
    hold_until_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= a;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    cfg_valid <= 1'b0;
    base_addr = a;
    restart_stream();
  endtask

  // Pop text words with random stalls and compare against the oldest expectation
  initial begin : text_sink
    int         stall;
    text_word_t want;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      stall = calm ? 0 : int'($urandom_range(0, MAX_WAIT));
      if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      while (empty !== 1'b0) @(posedge clk);
      if (text_due.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS) begin
          $display("%0t: unexpected word, expected none, actual text_char %02h last_of_run %0b",
                   $time, text_char, last_of_run);
        end
      end else begin
        want = text_due.pop_front();
        if (text_char !== want.ch) begin
          errors++;
          if (errors <= MAX_REPORTS) begin
            $display("%0t: text_char expected %02h actual %02h", $time, want.ch, text_char);
          end
        end
        if (last_of_run !== want.last) begin
          errors++;
          if (errors <= MAX_REPORTS) begin
            $display("%0t: last_of_run expected %0b actual %0b", $time, want.last, last_of_run);
          end
        end
      end
    end
  end

  // Abort a hung run
  initial begin : watchdog
    while (cycle_count < LIMIT_CYCLES) @(posedge clk);
    $display("Regression FAIL");
    $finish;
  end

  initial begin : stimulus
    dir_row_t row;
    int       len;
    int       sent;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Walk the directed table
    for (int r = 0; r < DIR_ROWS; r++) begin
      row = dir_rows[r];
      case (row.kind)
        ROW_CFG: write_load_address(row.val);
        ROW_END: send_item(ihex_pkg::REQ_END, row.val[7:0], row.want);
        default: send_item(ihex_pkg::REQ_DATA, row.val[7:0], row.want);
      endcase
    end

    // Random streams: mostly byte runs closed by an end marker, some cut short
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      calm = ($urandom_range(0, 4) == 0);
      case ($urandom_range(0, 7))
        0, 1:    write_load_address(pick_load_address());
        2:       hold_until_drained();
        default: ;
      endcase
      len = ($urandom_range(0, 7) == 0) ? int'($urandom_range(41, 72))
                                        : int'($urandom_range(0, 40));
      repeat (len) send_item(ihex_pkg::REQ_DATA, 8'($urandom), EXP_PREDICT);
      sent += len;
      if ($urandom_range(0, 9) != 0) begin
        send_item(ihex_pkg::REQ_END, 8'($urandom), EXP_PREDICT);
        sent++;
      end
    end

    calm = 1'b0;
    hold_until_drained();
    if (text_due.size() != 0) begin
      errors++;
      $display("%0t: %0d words expected, actual none", $time, text_due.size());
    end
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
